/* sv/polled_uart_register_device_defines.svh */
// Assertion macros shared by the port checkers of the polled UART block.
// No dependencies; included by the checker file.
`ifndef POLLED_UART_REGISTER_DEVICE_DEFINES_SVH
`define POLLED_UART_REGISTER_DEVICE_DEFINES_SVH

// Concurrent check that is switched off while reset is asserted.
`define PUR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("polled uart port check failed");

// Concurrent check that also holds during reset.
`define PUR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("polled uart port check failed");

`endif

/* sv/pur_pkg.sv */
// Shared types and constants of the polled UART register block.
// No dependencies; imported by every module of the block.
package pur_pkg;

  // Width of the rx and tx tick counters.
  localparam int COUNT_WIDTH = 16;
  // Width used to compare a counter against the tick period.
  localparam int CMP_W = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Request type codes.
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Bus register indexes.
  localparam logic [1:0] REG_RX_CTRL = 2'd0;
  localparam logic [1:0] REG_RX_DATA = 2'd1;
  localparam logic [1:0] REG_TX_CTRL = 2'd2;
  localparam logic [1:0] REG_TX_DATA = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_RX_ENABLE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TX_ENABLE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WORD_MODE   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TICK_PERIOD = 2'd3;

  localparam logic [15:0] TICK_PERIOD_RESET = 16'd1600;

  // Control register bit positions.
  localparam int CR_IE  = 0;
  localparam int CR_RDY = 1;
  localparam int CR_SET = 2;
  localparam int CR_CLR = 3;

  // One input item.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  reg_index;
    logic [31:0] write_data;
    logic        rx_valid;
    logic [7:0]  rx_byte;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [31:0] read_data;
    logic        rx_taken;
    logic        tx_valid;
    logic [31:0] tx_data;
    logic        rx_irq;
    logic        tx_irq;
  } rsp_t;

  // Configuration register contents.
  typedef struct packed {
    logic        rx_enable;
    logic        tx_enable;
    logic        wide_mode;
    logic [15:0] tick_period;
  } cfg_t;

  // Item handed to the rx and tx sides, with the strobe that commits it.
  typedef struct packed {
    logic fire;
    req_t req;
  } op_t;

  // Control word as read from a control register.
  function automatic logic [31:0] ctrl_word(input logic ie, input logic rdy, input logic pend);
    logic [31:0] w;
    w = '0;
    w[CR_IE]  = ie;
    w[CR_RDY] = rdy;
    w[CR_SET] = pend;
    return w;
  endfunction

endpackage

/* sv/pur_rx.sv */
// Receive side: rx tick counter, word assembly and rx control/data registers.
// Depends on pur_pkg.
module pur_rx import pur_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  op_t         op,
  input  cfg_t        cfg,
  output logic [31:0] read_data,
  output logic        taken,
  output logic        irq
);

  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [31:0] assembly, assembly_next;
  logic [2:0]  byte_pos, byte_pos_next;
  logic [31:0] value, value_next;
  logic        ready, ready_next;
  logic        int_enable, int_enable_next;
  logic        int_pending, int_pending_next;

  logic        fires;
  logic [1:0]  pos;
  logic [31:0] merged;

  // The side fires once its count has reached the period.
  assign fires = cfg.rx_enable && (CMP_W'(tick_count) >= CMP_W'(cfg.tick_period));
  assign pos   = byte_pos[1:0];

  // Place the offered byte, most significant byte first.
  always_comb begin
    case (pos)
      2'd0:    merged = assembly | {op.req.rx_byte, 24'd0};
      2'd1:    merged = assembly | {8'd0, op.req.rx_byte, 16'd0};
      2'd2:    merged = assembly | {16'd0, op.req.rx_byte, 8'd0};
      default: merged = assembly | {24'd0, op.req.rx_byte};
    endcase
  end

  // Effect of the current item on the receive state.
  always_comb begin
    tick_count_next  = tick_count;
    assembly_next    = assembly;
    byte_pos_next    = byte_pos;
    value_next       = value;
    ready_next       = ready;
    int_enable_next  = int_enable;
    int_pending_next = int_pending;
    read_data        = '0;
    taken            = 1'b0;
    if (op.fire) begin
      case (op.req.req_type)
        REQ_READ: begin
          case (op.req.reg_index)
            REG_RX_CTRL: begin
              if (cfg.rx_enable) read_data = ctrl_word(int_enable, ready, int_pending);
            end
            REG_RX_DATA: begin
              if (ready) begin
                read_data        = value;
                ready_next       = 1'b0;
                int_pending_next = 1'b0;
              end
            end
            default: ;
          endcase
        end
        REQ_WRITE: begin
          if (op.req.reg_index == REG_RX_CTRL && cfg.rx_enable) begin
            int_enable_next = op.req.write_data[CR_IE];
          end
        end
        REQ_TICK: begin
          if (fires) begin
            tick_count_next = '0;
            if (op.req.rx_valid) begin
              taken = 1'b1;
              if (cfg.wide_mode) begin
                if (pos == 2'd3) begin
                  value_next    = merged;
                  ready_next    = 1'b1;
                  assembly_next = '0;
                  byte_pos_next = '0;
                  if (int_enable) int_pending_next = 1'b1;
                end else begin
                  assembly_next = merged;
                  byte_pos_next = {1'b0, pos} + 3'd1;
                end
              end else begin
                value_next = {24'd0, op.req.rx_byte};
                ready_next = 1'b1;
                if (int_enable) int_pending_next = 1'b1;
              end
            end
          end else begin
            tick_count_next = tick_count + COUNT_WIDTH'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign irq = int_pending_next;

  // Receive state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      assembly    <= '0;
      byte_pos    <= '0;
      value       <= '0;
      ready       <= 1'b0;
      int_enable  <= 1'b0;
      int_pending <= 1'b0;
    end else begin
      tick_count  <= tick_count_next;
      assembly    <= assembly_next;
      byte_pos    <= byte_pos_next;
      value       <= value_next;
      ready       <= ready_next;
      int_enable  <= int_enable_next;
      int_pending <= int_pending_next;
    end
  end

endmodule

/* sv/pur_tx.sv */
// Transmit side: tx tick counter, send sequencing and tx control/data registers.
// Depends on pur_pkg.
module pur_tx import pur_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  op_t         op,
  input  cfg_t        cfg,
  output logic [31:0] read_data,
  output logic        tx_valid,
  output logic [31:0] tx_data,
  output logic        irq
);

  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [31:0] value, value_next;
  logic        free, free_next;
  logic [1:0]  step, step_next;
  logic [31:0] latched_word, latched_word_next;
  logic        int_enable, int_enable_next;
  logic        int_pending, int_pending_next;

  logic        fires;
  logic [1:0]  step_inc;
  logic        set_ie;
  logic        set_pend;

  assign fires    = cfg.tx_enable && (CMP_W'(tick_count) >= CMP_W'(cfg.tick_period));
  assign step_inc = step + 2'd1;

  // Effect of the current item on the transmit state.
  always_comb begin
    tick_count_next   = tick_count;
    value_next        = value;
    free_next         = free;
    step_next         = step;
    latched_word_next = latched_word;
    int_enable_next   = int_enable;
    int_pending_next  = int_pending;
    read_data         = '0;
    tx_valid          = 1'b0;
    tx_data           = '0;
    set_ie            = op.req.write_data[CR_IE];
    set_pend          = int_pending || (set_ie && op.req.write_data[CR_SET]);
    if (op.fire) begin
      case (op.req.req_type)
        REQ_READ: begin
          if (op.req.reg_index == REG_TX_CTRL && cfg.tx_enable) begin
            read_data = ctrl_word(int_enable, free, int_pending);
          end
        end
        REQ_WRITE: begin
          if (cfg.tx_enable) begin
            case (op.req.reg_index)
              REG_TX_CTRL: begin
                // Set applies first, then clear acts on the updated level.
                int_enable_next  = set_ie;
                int_pending_next = set_pend && !op.req.write_data[CR_CLR];
              end
              REG_TX_DATA: begin
                if (free) begin
                  value_next = op.req.write_data;
                  free_next  = 1'b0;
                end
                int_pending_next = 1'b0;
              end
              default: ;
            endcase
          end
        end
        REQ_TICK: begin
          if (fires) begin
            tick_count_next = '0;
            if (!free) begin
              if (cfg.wide_mode) begin
                // The word is captured on the first firing and sent on the third.
                if (step == 2'd0) latched_word_next = value;
                if (step_inc == 2'd3) begin
                  tx_valid  = 1'b1;
                  tx_data   = latched_word_next;
                  step_next = 2'd0;
                  free_next = 1'b1;
                  if (int_enable) int_pending_next = 1'b1;
                end else begin
                  step_next = step_inc;
                end
              end else begin
                tx_valid  = 1'b1;
                tx_data   = {24'd0, value[7:0]};
                free_next = 1'b1;
                if (int_enable) int_pending_next = 1'b1;
              end
            end
          end else begin
            tick_count_next = tick_count + COUNT_WIDTH'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign irq = int_pending_next;

  // Transmit state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      value        <= '0;
      free         <= 1'b1;
      step         <= '0;
      latched_word <= '0;
      int_enable   <= 1'b0;
      int_pending  <= 1'b0;
    end else begin
      tick_count   <= tick_count_next;
      value        <= value_next;
      free         <= free_next;
      step         <= step_next;
      latched_word <= latched_word_next;
      int_enable   <= int_enable_next;
      int_pending  <= int_pending_next;
    end
  end

endmodule

/* sv/polled_uart_register_device.sv */
// Polled UART register block, top level: input register, rx and tx sides, result register.
// An item waits in the input register until the result register can take its result.
// Throughput: one item per cycle while results are taken; each item is handled in one pass.
// Reset (synchronous, active high) clears all state, sets tx free and loads the
// configuration defaults; the item and config ports are not ready during reset.
// Depends on pur_pkg, pur_rx and pur_tx.
module polled_uart_register_device import pur_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  req_t                   req,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output rsp_t                   rsp,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  req_t  req_q;
  logic  req_q_valid;
  rsp_t  rsp_q;
  logic  rsp_q_valid;
  cfg_t  cfg;
  op_t   op;
  logic  advance;
  rsp_t  rsp_next;

  logic [31:0] rx_read_data;
  logic [31:0] tx_read_data;
  logic        rx_taken;
  logic        tx_valid;
  logic [31:0] tx_data;
  logic        rx_irq;
  logic        tx_irq;

  // The held item is processed whenever the result register can take its result.
  assign advance   = req_q_valid && (!rsp_q_valid || rsp_ready);
  assign req_ready = !rst && (!req_q_valid || advance);
  assign cfg_ready = !rst;
  assign op.fire   = advance;
  assign op.req    = req_q;

  pur_rx u_rx (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .cfg       (cfg),
    .read_data (rx_read_data),
    .taken     (rx_taken),
    .irq       (rx_irq)
  );

  pur_tx u_tx (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .cfg       (cfg),
    .read_data (tx_read_data),
    .tx_valid  (tx_valid),
    .tx_data   (tx_data),
    .irq       (tx_irq)
  );

  // The two sides decode disjoint registers, so their read data simply merge.
  always_comb begin
    rsp_next.read_data = rx_read_data | tx_read_data;
    rsp_next.rx_taken  = rx_taken;
    rsp_next.tx_valid  = tx_valid;
    rsp_next.tx_data   = tx_data;
    rsp_next.rx_irq    = rx_irq;
    rsp_next.tx_irq    = tx_irq;
  end

  // Input and result handshake flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
      rsp_q_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) req_q_valid <= 1'b1;
      else if (advance)           req_q_valid <= 1'b0;
      if (advance)                rsp_q_valid <= 1'b1;
      else if (rsp_ready)         rsp_q_valid <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) req_q <= req;
    if (advance)                rsp_q <= rsp_next;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rx_enable   <= 1'b1;
      cfg.tx_enable   <= 1'b1;
      cfg.wide_mode   <= 1'b0;
      cfg.tick_period <= TICK_PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RX_ENABLE:   cfg.rx_enable   <= cfg_data[0];
        CFG_TX_ENABLE:   cfg.tx_enable   <= cfg_data[0];
        CFG_WORD_MODE:   cfg.wide_mode   <= cfg_data[0];
        CFG_TICK_PERIOD: cfg.tick_period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign rsp_valid = rsp_q_valid;
  assign rsp       = rsp_q;

endmodule

/* sv/pur_checker.sv */
// Port-level checks of the polled UART register block, bound to the top level.
// Depends on pur_pkg and polled_uart_register_device_defines.svh.
`include "polled_uart_register_device_defines.svh"

module pur_checker import pur_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // A stalled result stays put.
  `PUR_ASSERT(rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))

  // No result is shown right after reset.
  `PUR_ASSERT_ALWAYS(rsp_idle_after_reset, clk, $past(rst) |-> !rsp_valid)

  // A drained output never blocks the input side.
  `PUR_ASSERT(no_input_stall, clk, rst, rsp_ready |-> req_ready)

  // Sent data only comes from ticks, which return no read data.
  `PUR_ASSERT(tx_on_tick_only, clk, rst, rsp_valid && rsp.tx_valid |-> rsp.read_data == 32'd0)

endmodule

bind polled_uart_register_device pur_checker u_pur_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

/* verif/uart_reg_checker.sv */
`timescale 1ns / 1ps
// Checker for the polled UART register block: keeps its own copy of the registers and
// counters, predicts one result per accepted item and compares it field by field.
// Depends on pur_pkg for the item, result and configuration types.
module uart_reg_checker import pur_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  logic                   req_ready,
  input  req_t                   req,
  input  logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  rsp_t                   rsp,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     outstanding,
  output int                     errors
);

  // Shadow configuration.
  cfg_t cfg_shadow;

  // Shadow state of the receive side.
  logic [COUNT_WIDTH-1:0] rx_count;
  logic [31:0]            rx_shift;
  logic [1:0]             rx_pos;
  logic [31:0]            rx_word;
  logic                   rx_full;
  logic                   rx_ie;
  logic                   rx_pend;

  // Shadow state of the transmit side.
  logic [COUNT_WIDTH-1:0] tx_count;
  logic [31:0]            tx_word;
  logic                   tx_idle;
  logic [1:0]             tx_phase;
  logic [31:0]            tx_hold;
  logic                   tx_ie;
  logic                   tx_pend;

  rsp_t pending_results[$];
  int   result_count;

  initial begin
    errors = 0;
    outstanding = 0;
    result_count = 0;
  end

  // Reset values of the shadow registers.
  function automatic void clear_uart_state();
    cfg_shadow.rx_enable   = 1'b1;
    cfg_shadow.tx_enable   = 1'b1;
    cfg_shadow.wide_mode   = 1'b0;
    cfg_shadow.tick_period = TICK_PERIOD_RESET;
    rx_count = '0;
    rx_shift = '0;
    rx_pos   = '0;
    rx_word  = '0;
    rx_full  = 1'b0;
    rx_ie    = 1'b0;
    rx_pend  = 1'b0;
    tx_count = '0;
    tx_word  = '0;
    tx_idle  = 1'b1;
    tx_phase = '0;
    tx_hold  = '0;
    tx_ie    = 1'b0;
    tx_pend  = 1'b0;
  endfunction

  // Control register layout as the bus sees it.
  function automatic logic [31:0] status_word(input logic ie, input logic rdy, input logic pend);
    logic [31:0] w;
    w = '0;
    w[CR_IE]  = ie;
    w[CR_RDY] = rdy;
    w[CR_SET] = pend;
    return w;
  endfunction

  // Expected result of one item; updates the shadow state as the block would.
  function automatic rsp_t predict_uart_item(input req_t r);
    rsp_t o;
    int   p;
    o = '0;
    p = 0;
    case (r.req_type)
      REQ_READ: begin
        case (r.reg_index)
          REG_RX_CTRL: begin
            if (cfg_shadow.rx_enable) o.read_data = status_word(rx_ie, rx_full, rx_pend);
          end
          REG_RX_DATA: begin
            if (rx_full) begin
              o.read_data = rx_word;
              rx_full = 1'b0;
              rx_pend = 1'b0;
            end
          end
          REG_TX_CTRL: begin
            if (cfg_shadow.tx_enable) o.read_data = status_word(tx_ie, tx_idle, tx_pend);
          end
          default: ;
        endcase
      end
      REQ_WRITE: begin
        case (r.reg_index)
          REG_RX_CTRL: begin
            if (cfg_shadow.rx_enable) rx_ie = r.write_data[CR_IE];
          end
          REG_TX_CTRL: begin
            if (cfg_shadow.tx_enable) begin
              tx_ie = r.write_data[CR_IE];
              if (tx_ie && r.write_data[CR_SET]) tx_pend = 1'b1;
              if (tx_pend && r.write_data[CR_CLR]) tx_pend = 1'b0;
            end
          end
          REG_TX_DATA: begin
            if (cfg_shadow.tx_enable) begin
              // A write while a value is still pending keeps the old value.
              if (tx_idle) begin
                tx_word = r.write_data;
                tx_idle = 1'b0;
              end
              tx_pend = 1'b0;
            end
          end
          default: ;
        endcase
      end
      REQ_TICK: begin
        // Receive side: take the offered byte when the counter fires.
        if (cfg_shadow.rx_enable && 32'(rx_count) >= 32'(cfg_shadow.tick_period)) begin
          if (r.rx_valid) begin
            o.rx_taken = 1'b1;
            if (cfg_shadow.wide_mode) begin
              p = int'(rx_pos);
              rx_shift = rx_shift | ({24'b0, r.rx_byte} << (8 * (3 - p)));
              p = p + 1;
              if (p == 4) begin
                rx_word  = rx_shift;
                rx_full  = 1'b1;
                rx_shift = '0;
                p = 0;
                if (rx_ie) rx_pend = 1'b1;
              end
              rx_pos = 2'(p);
            end else begin
              rx_word = {24'b0, r.rx_byte};
              rx_full = 1'b1;
              if (rx_ie) rx_pend = 1'b1;
            end
          end
          rx_count = '0;
        end else begin
          rx_count = rx_count + COUNT_WIDTH'(1);
        end
        // Transmit side: send the pending value, a word only on the third firing.
        if (cfg_shadow.tx_enable && 32'(tx_count) >= 32'(cfg_shadow.tick_period)) begin
          if (!tx_idle) begin
            if (cfg_shadow.wide_mode) begin
              if (tx_phase == 2'd0) tx_hold = tx_word;
              tx_phase = tx_phase + 2'd1;
              if (tx_phase == 2'd3) begin
                o.tx_valid = 1'b1;
                o.tx_data  = tx_hold;
                if (tx_ie) tx_pend = 1'b1;
                tx_phase = '0;
                tx_idle  = 1'b1;
              end
            end else begin
              o.tx_valid = 1'b1;
              o.tx_data  = {24'b0, tx_word[7:0]};
              if (tx_ie) tx_pend = 1'b1;
              tx_idle = 1'b1;
            end
          end
          tx_count = '0;
        end else begin
          tx_count = tx_count + COUNT_WIDTH'(1);
        end
      end
      default: ;
    endcase
    o.rx_irq = rx_pend;
    o.tx_irq = tx_pend;
    return o;
  endfunction

  // Prints one mismatch and counts it.
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR: result %0d %s: got %h, expected %h", result_count, what, got, want);
    errors++;
  endtask

  task automatic compare_result(input rsp_t got, input rsp_t want);
    if (got.read_data !== want.read_data) report("read_data", got.read_data, want.read_data);
    if (got.rx_taken !== want.rx_taken) report("rx_taken", 32'(got.rx_taken), 32'(want.rx_taken));
    if (got.tx_valid !== want.tx_valid) report("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
    if (got.tx_data !== want.tx_data) report("tx_data", got.tx_data, want.tx_data);
    if (got.rx_irq !== want.rx_irq) report("rx_irq", 32'(got.rx_irq), 32'(want.rx_irq));
    if (got.tx_irq !== want.tx_irq) report("tx_irq", 32'(got.tx_irq), 32'(want.tx_irq));
  endtask

  // Watch the three channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_uart_state();
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RX_ENABLE:   cfg_shadow.rx_enable   = cfg_data[0];
          CFG_TX_ENABLE:   cfg_shadow.tx_enable   = cfg_data[0];
          CFG_WORD_MODE:   cfg_shadow.wide_mode   = cfg_data[0];
          CFG_TICK_PERIOD: cfg_shadow.tick_period = cfg_data[15:0];
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) report("result with nothing expected", rsp.read_data, '0);
        else compare_result(rsp, pending_results.pop_front());
        result_count++;
      end
      if (req_valid && req_ready) pending_results.push_back(predict_uart_item(req));
      outstanding <= pending_results.size();
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Top of the polled UART register block testbench: clock, reset, item and configuration
// stimulus, result-side stalls and the verdict. Depends on pur_pkg and uart_reg_checker.
module testbench;
  import pur_pkg::*;

  // The one request type the block does not use.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_ready;
  req_t                   req;
  logic                   rsp_valid;
  logic                   rsp_ready;
  rsp_t                   rsp;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int results_open;
  int check_errors;
  bit idle_on;
  bit hold_results;

  polled_uart_register_device dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  uart_reg_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (results_open),
    .errors      (check_errors)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic req_t request(input logic [1:0] kind, input logic [1:0] idx,
                                   input logic [31:0] data, input logic valid,
                                   input logic [7:0] rx_in);
    req_t r;
    r.req_type   = kind;
    r.reg_index  = idx;
    r.write_data = data;
    r.rx_valid   = valid;
    r.rx_byte    = rx_in;
    return r;
  endfunction

  // Ticks most often, with reads of rx data and writes of tx data favored.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 48) r.req_type = REQ_TICK;
    else if (pick < 72) r.req_type = REQ_READ;
    else if (pick < 96) r.req_type = REQ_WRITE;
    else r.req_type = REQ_UNUSED;
    r.reg_index = 2'($urandom_range(0, 3));
    if (r.req_type == REQ_READ && $urandom_range(0, 1) == 1) r.reg_index = REG_RX_DATA;
    if (r.req_type == REQ_WRITE && $urandom_range(0, 1) == 1) r.reg_index = REG_TX_DATA;
    r.write_data = $urandom();
    r.rx_valid   = ($urandom_range(0, 3) != 0);
    r.rx_byte    = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Offers one item after a random gap; returns at the falling edge after acceptance
  // with valid still high, so a back-to-back item keeps it up.
  task automatic offer_request(input req_t r);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (results_open != 0);
    @(negedge clk);
  endtask

  task automatic put_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Writes all four configuration registers while the block is idle.
  task automatic set_config(input bit rx_en, input bit tx_en, input bit word,
                            input logic [15:0] period);
    drain_results();
    put_cfg(CFG_RX_ENABLE, CFG_DATA_W'(rx_en));
    put_cfg(CFG_TX_ENABLE, CFG_DATA_W'(tx_en));
    put_cfg(CFG_WORD_MODE, CFG_DATA_W'(word));
    put_cfg(CFG_TICK_PERIOD, period);
    cfg_valid <= 1'b0;
  endtask

  // Random items; optionally a long result-side hold or a full drain partway through.
  task automatic run_random(input int count, input int hold_at, input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_results = 1'b1;
      if (i == pause_at) drain_results();
      offer_request(random_request());
    end
  endtask

  // Result side: random stalls, with one long hold when asked for.
  initial begin
    int gap;
    do @(negedge clk); while (rst);
    forever begin
      gap = idle_on ? $urandom_range(0, 14) : 0;
      if (hold_results) begin
        gap = 80;
        hold_results = 1'b0;
      end
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
      @(negedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    rsp_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    idle_on      = 1'b1;
    hold_results = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Register access at the reset settings; the counters are far from firing.
    offer_request(request(REQ_READ, REG_RX_CTRL, '0, 1'b0, 8'h00));
    offer_request(request(REQ_READ, REG_RX_DATA, '0, 1'b0, 8'h00));
    offer_request(request(REQ_READ, REG_TX_CTRL, '0, 1'b0, 8'h00));
    offer_request(request(REQ_READ, REG_TX_DATA, '0, 1'b0, 8'h00));
    offer_request(request(REQ_WRITE, REG_RX_CTRL, 32'h1, 1'b0, 8'h00));
    offer_request(request(REQ_WRITE, REG_TX_CTRL, 32'h5, 1'b0, 8'h00));
    offer_request(request(REQ_READ, REG_TX_CTRL, '0, 1'b0, 8'h00));
    offer_request(request(REQ_WRITE, REG_TX_CTRL, 32'h9, 1'b0, 8'h00));
    offer_request(request(REQ_WRITE, REG_TX_CTRL, 32'h4, 1'b0, 8'h00));
    offer_request(request(REQ_WRITE, REG_RX_DATA, '1, 1'b1, 8'hFF));
    offer_request(request(REQ_UNUSED, REG_TX_DATA, '1, 1'b1, 8'hFF));
    offer_request(request(REQ_TICK, REG_RX_CTRL, '0, 1'b1, 8'hFF));

    // Zero period: both sides fire on every tick.
    set_config(1'b1, 1'b1, 1'b0, 16'd0);
    offer_request(request(REQ_TICK, REG_RX_CTRL, '0, 1'b1, 8'hFF));
    offer_request(request(REQ_READ, REG_RX_CTRL, '0, 1'b0, 8'h00));
    offer_request(request(REQ_READ, REG_RX_DATA, '0, 1'b0, 8'h00));
    offer_request(request(REQ_TICK, REG_RX_CTRL, '0, 1'b0, 8'hA5));
    offer_request(request(REQ_WRITE, REG_TX_CTRL, 32'h1, 1'b0, 8'h00));
    offer_request(request(REQ_WRITE, REG_TX_DATA, '1, 1'b0, 8'h00));
    offer_request(request(REQ_WRITE, REG_TX_DATA, 32'h12345678, 1'b0, 8'h00));
    offer_request(request(REQ_TICK, REG_RX_CTRL, '0, 1'b1, 8'h00));
    offer_request(request(REQ_WRITE, REG_TX_DATA, '0, 1'b0, 8'h00));
    offer_request(request(REQ_TICK, REG_RX_CTRL, '0, 1'b0, 8'h00));
    offer_request(request(REQ_READ, REG_TX_CTRL, '0, 1'b0, 8'h00));
    offer_request(request(REQ_WRITE, REG_TX_CTRL, 32'hD, 1'b0, 8'h00));
    offer_request(request(REQ_READ, REG_RX_DATA, '0, 1'b0, 8'h00));

    // Byte mode at zero period, with one long result-side hold.
    run_random(300, 150, -1);

    // Word mode; the sender drains once partway through.
    set_config(1'b1, 1'b1, 1'b1, 16'd2);
    run_random(300, -1, 150);

    // Receive side off, then transmit side off with the word mode switched back.
    set_config(1'b0, 1'b1, 1'b1, 16'd1);
    run_random(200, -1, -1);
    set_config(1'b1, 1'b0, 1'b0, 16'd3);
    run_random(200, 100, -1);

    // Largest period, back to back with no stalls.
    idle_on = 1'b0;
    set_config(1'b1, 1'b1, 1'b0, 16'hFFFF);
    run_random(60, -1, -1);

    // Both sides off while the counters keep advancing, then a short period.
    set_config(1'b0, 1'b0, 1'b1, 16'd10);
    for (int i = 0; i < 40; i++) begin
      offer_request(request(REQ_TICK, REG_RX_CTRL, '0, 1'($urandom_range(0, 1)),
                            8'($urandom_range(0, 255))));
    end
    idle_on = 1'b1;
    set_config(1'b1, 1'b1, 1'b1, 16'd10);
    run_random(300, -1, -1);

    // Byte mode at period one, with any word left mid-way.
    set_config(1'b1, 1'b1, 1'b0, 16'd1);
    run_random(240, 60, 180);

    drain_results();
    repeat (4) @(posedge clk);
    if (check_errors == 0 && results_open == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
